FILE: hw/rtl/bcs_pkg.sv
// bcs_pkg: shared types and codes for the bootloader command sequencer
// used by bootloader_command_sequencer and its port checker; no dependencies
package bcs_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PREPARE = 2'd1,
    PH_FLASH   = 2'd2,
    PH_EXIT    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_CONNECT = 2'd0,
    CMD_PREPARE = 2'd1,
    CMD_FLASH   = 2'd2,
    CMD_EXIT    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_SIZE    = 3'd2,
    ST_FWVER   = 3'd3,
    ST_HWVER   = 3'd4,
    ST_ERASE   = 3'd5,
    ST_WRITE   = 3'd6,
    ST_VALID   = 3'd7
  } status_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FW_VERSION_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HW_VERSION_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_APP_BASE_ADDRESS = 3'd4;

  localparam logic [2:0] CHECK_ENABLES_RST = 3'b111;

endpackage

FILE: hw/rtl/bootloader_command_sequencer.sv
// bootloader_command_sequencer: firmware-update command sequencer, top level
// depends on bcs_pkg
//
// One request in, one reply out. Each command is decoded against the session
// phase and the address and byte counters in a single pass of compare and add
// logic, and the reply is written to the output register as the request is
// taken. A new request is taken every cycle as long as the output
// register is empty or its reply is being taken in the same cycle, so the
// sustained rate is one command per clock. Configuration writes are taken
// every cycle (cfg_ready is tied high) and are meant for idle periods only.
module bootloader_command_sequencer
  import bcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // requests
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_image_size,
  input  logic [31:0]          in_fw_version,
  input  logic [31:0]          in_hw_version,
  input  logic [15:0]          in_chunk_bytes,
  input  logic                 in_erase_ok,
  input  logic                 in_write_ok,
  input  logic                 in_image_valid,
  // replies
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_reply_kind,
  output logic [2:0]           out_reply_status,
  output logic [1:0]           out_phase_after,
  output logic                 out_erase_request,
  output logic                 out_write_request,
  output logic [31:0]          out_write_address,
  output logic                 out_start_application,
  output logic                 out_boot_reason_com
);

  // configuration registers
  logic [31:0] image_size_limit_r;
  logic [31:0] fw_version_limit_r;
  logic [31:0] hw_version_limit_r;
  logic [2:0]  check_enables_r;
  logic [31:0] app_base_address_r;

  // session state
  phase_t      phase_r,           phase_nxt;
  logic [31:0] working_address_r, working_address_nxt;
  logic [31:0] bytes_written_r,   bytes_written_nxt;
  logic [31:0] expected_size_r,   expected_size_nxt;
  logic        reason_com_r,      reason_com_nxt;

  // reply register
  logic        out_valid_r;
  cmd_t        reply_kind_r;
  status_t     reply_status_r,    reply_status_nxt;
  logic        erase_request_r,   erase_request_nxt;
  logic        write_request_r,   write_request_nxt;
  logic [31:0] write_address_r,   write_address_nxt;
  logic        start_app_r,       start_app_nxt;

  logic    in_fire;
  cmd_t    cmd;
  status_t check_status;
  logic    room_left;
  logic [31:0] chunk_ext;
  logic [31:0] bytes_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cmd       = cmd_t'(in_command);
  assign chunk_ext = {16'd0, in_chunk_bytes};
  assign bytes_sum = bytes_written_r + chunk_ext;
  assign room_left = bytes_written_r < expected_size_r;

  // first enabled failing limit check wins
  always_comb begin
    if (check_enables_r[0] && (in_image_size > image_size_limit_r)) begin
      check_status = ST_SIZE;
    end else if (check_enables_r[1] && (in_fw_version > fw_version_limit_r)) begin
      check_status = ST_FWVER;
    end else if (check_enables_r[2] && (in_hw_version > hw_version_limit_r)) begin
      check_status = ST_HWVER;
    end else if (!in_erase_ok) begin
      check_status = ST_ERASE;
    end else begin
      check_status = ST_OK;
    end
  end

  // next state
  always_comb begin
    phase_nxt           = phase_r;
    working_address_nxt = working_address_r;
    bytes_written_nxt   = bytes_written_r;
    expected_size_nxt   = expected_size_r;
    reason_com_nxt      = reason_com_r;
    case (cmd)
      CMD_CONNECT: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt      = PH_PREPARE;
          reason_com_nxt = 1'b1;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      CMD_PREPARE: begin
        if ((phase_r == PH_PREPARE) && (check_status == ST_OK)) begin
          phase_nxt           = PH_FLASH;
          expected_size_nxt   = in_image_size;
          working_address_nxt = app_base_address_r;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      CMD_FLASH: begin
        if ((phase_r == PH_FLASH) && room_left && in_write_ok) begin
          working_address_nxt = working_address_r + chunk_ext;
          bytes_written_nxt   = bytes_sum;
          if (bytes_sum == expected_size_r) begin
            phase_nxt = PH_EXIT;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      CMD_EXIT: begin
        if (phase_r == PH_EXIT) begin
          if (in_image_valid) begin
            reason_com_nxt = 1'b0;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // entering idle clears the session counters
    if (phase_nxt == PH_IDLE) begin
      working_address_nxt = '0;
      bytes_written_nxt   = '0;
      expected_size_nxt   = '0;
    end
  end

  // reply fields
  always_comb begin
    reply_status_nxt  = ST_OK;
    erase_request_nxt = 1'b0;
    write_request_nxt = 1'b0;
    write_address_nxt = '0;
    start_app_nxt     = 1'b0;
    case (cmd)
      CMD_CONNECT: begin
        if (phase_r != PH_IDLE) begin
          reply_status_nxt = ST_INVALID;
        end
      end
      CMD_PREPARE: begin
        if (phase_r == PH_PREPARE) begin
          reply_status_nxt  = check_status;
          erase_request_nxt = (check_status == ST_OK) || (check_status == ST_ERASE);
        end else begin
          reply_status_nxt = ST_INVALID;
        end
      end
      CMD_FLASH: begin
        if (phase_r != PH_FLASH) begin
          reply_status_nxt = ST_INVALID;
        end else if (!room_left) begin
          reply_status_nxt = ST_WRITE;
        end else begin
          write_request_nxt = 1'b1;
          write_address_nxt = working_address_r;
          if (!in_write_ok) begin
            reply_status_nxt = ST_WRITE;
          end
        end
      end
      CMD_EXIT: begin
        if (phase_r != PH_EXIT) begin
          reply_status_nxt = ST_INVALID;
        end else if (in_image_valid) begin
          start_app_nxt = 1'b1;
        end else begin
          reply_status_nxt = ST_VALID;
        end
      end
      default: begin
        reply_status_nxt = ST_INVALID;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_limit_r <= '0;
      fw_version_limit_r <= '0;
      hw_version_limit_r <= '0;
      check_enables_r    <= CHECK_ENABLES_RST;
      app_base_address_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_SIZE_LIMIT: image_size_limit_r <= cfg_data;
        REG_FW_VERSION_LIMIT: fw_version_limit_r <= cfg_data;
        REG_HW_VERSION_LIMIT: hw_version_limit_r <= cfg_data;
        REG_CHECK_ENABLES:    check_enables_r    <= cfg_data[2:0];
        REG_APP_BASE_ADDRESS: app_base_address_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      working_address_r <= '0;
      bytes_written_r   <= '0;
      expected_size_r   <= '0;
      reason_com_r      <= 1'b0;
    end else if (in_fire) begin
      phase_r           <= phase_nxt;
      working_address_r <= working_address_nxt;
      bytes_written_r   <= bytes_written_nxt;
      expected_size_r   <= expected_size_nxt;
      reason_com_r      <= reason_com_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // reply payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      reply_kind_r    <= cmd;
      reply_status_r  <= reply_status_nxt;
      erase_request_r <= erase_request_nxt;
      write_request_r <= write_request_nxt;
      write_address_r <= write_address_nxt;
      start_app_r     <= start_app_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_reply_kind        = reply_kind_r;
  assign out_reply_status      = reply_status_r;
  // phase and reason registers already hold the post-command values
  assign out_phase_after       = phase_r;
  assign out_erase_request     = erase_request_r;
  assign out_write_request     = write_request_r;
  assign out_write_address     = write_address_r;
  assign out_start_application = start_app_r;
  assign out_boot_reason_com   = reason_com_r;

endmodule

FILE: hw/rtl/bcs_checker.sv
// bcs_checker: port-level assertions for bootloader_command_sequencer
// depends on bcs_pkg; bound to the top level at the end of this file
module bcs_checker
  import bcs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           in_command,
  input logic [31:0]          in_image_size,
  input logic [31:0]          in_fw_version,
  input logic [31:0]          in_hw_version,
  input logic [15:0]          in_chunk_bytes,
  input logic                 in_erase_ok,
  input logic                 in_write_ok,
  input logic                 in_image_valid,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_reply_kind,
  input logic [2:0]           out_reply_status,
  input logic [1:0]           out_phase_after,
  input logic                 out_erase_request,
  input logic                 out_write_request,
  input logic [31:0]          out_write_address,
  input logic                 out_start_application,
  input logic                 out_boot_reason_com
);

  // a stalled reply holds
  a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reply_status)
      && $stable(out_reply_kind) && $stable(out_write_address))
    else $error("stalled reply changed");

  // every taken request has its reply valid in the next cycle
  a_reply_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && (out_reply_kind == $past(in_command)))
    else $error("reply missing or wrong kind after request");

  // erase only on prepare that passed the limit checks
  a_erase_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_erase_request |-> (out_reply_kind == CMD_PREPARE)
      && ((out_reply_status == ST_OK) || (out_reply_status == ST_ERASE)))
    else $error("erase request on wrong reply");

  // start only on a good exit, leaving the session in exit with reason cleared
  a_start_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_application |-> (out_reply_kind == CMD_EXIT)
      && (out_reply_status == ST_OK) && (out_phase_after == PH_EXIT)
      && !out_boot_reason_com)
    else $error("start application on wrong reply");

  // invalid request always drops the session
  a_invalid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reply_status == ST_INVALID) |-> out_phase_after == PH_IDLE)
    else $error("invalid request left session open");

endmodule

bind bootloader_command_sequencer bcs_checker u_bcs_checker (.*);

FILE: tb/bcs_reply_checker.sv
// bcs_reply_checker: watches the request, reply and register ports of the
// bootloader command sequencer, predicts every reply and compares it
// depends on bcs_pkg; instantiated by bootloader_command_sequencer_tb
module bcs_reply_checker
  import bcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_image_size,
  input  logic [31:0]          in_fw_version,
  input  logic [31:0]          in_hw_version,
  input  logic [15:0]          in_chunk_bytes,
  input  logic                 in_erase_ok,
  input  logic                 in_write_ok,
  input  logic                 in_image_valid,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           out_reply_kind,
  input  logic [2:0]           out_reply_status,
  input  logic [1:0]           out_phase_after,
  input  logic                 out_erase_request,
  input  logic                 out_write_request,
  input  logic [31:0]          out_write_address,
  input  logic                 out_start_application,
  input  logic                 out_boot_reason_com,
  output phase_t               session_phase,
  output int unsigned          requests_seen,
  output int unsigned          replies_due,
  output int unsigned          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t        kind;
    status_t     status;
    phase_t      phase;
    logic        erase_req;
    logic        write_req;
    logic [31:0] waddr;
    logic        start;
    logic        stay_com;
  } reply_t;

  logic [31:0] size_limit;
  logic [31:0] fw_limit;
  logic [31:0] hw_limit;
  logic [2:0]  checks_on;
  logic [31:0] app_base;

  logic [31:0] wr_addr;
  logic [31:0] bytes_done;
  logic [31:0] image_len;
  logic        stay_com;

  reply_t replies_q[$];

  function automatic void drop_session();
    session_phase = PH_IDLE;
    wr_addr       = '0;
    bytes_done    = '0;
    image_len     = '0;
  endfunction

  function automatic reply_t advance_session(cmd_t cmd, logic [31:0] size, logic [31:0] fw,
                                             logic [31:0] hw, logic [15:0] chunk,
                                             logic erase_ok, logic write_ok,
                                             logic image_valid);
    reply_t rep;
    rep        = '0;
    rep.kind   = cmd;
    rep.status = ST_OK;
    case (cmd)
      CMD_CONNECT: begin
        if (session_phase == PH_IDLE) begin
          stay_com      = 1'b1;
          session_phase = PH_PREPARE;
        end else begin
          rep.status = ST_INVALID;
          drop_session();
        end
      end
      CMD_PREPARE: begin
        if (session_phase == PH_PREPARE) begin
          // first enabled failing check wins
          if (checks_on[0] && size > size_limit)
            rep.status = ST_SIZE;
          else if (checks_on[1] && fw > fw_limit)
            rep.status = ST_FWVER;
          else if (checks_on[2] && hw > hw_limit)
            rep.status = ST_HWVER;
          if (rep.status == ST_OK) begin
            rep.erase_req = 1'b1;
            if (!erase_ok)
              rep.status = ST_ERASE;
          end
        end else begin
          rep.status = ST_INVALID;
        end
        if (rep.status == ST_OK) begin
          session_phase = PH_FLASH;
          image_len     = size;
          wr_addr       = app_base;
        end else begin
          drop_session();
        end
      end
      CMD_FLASH: begin
        if (session_phase != PH_FLASH) begin
          rep.status = ST_INVALID;
          drop_session();
        end else if (bytes_done < image_len) begin
          rep.write_req = 1'b1;
          rep.waddr     = wr_addr;
          if (write_ok) begin
            wr_addr    = wr_addr + {16'd0, chunk};
            bytes_done = bytes_done + {16'd0, chunk};
            // overshoot keeps the session in flash
            if (bytes_done == image_len)
              session_phase = PH_EXIT;
          end else begin
            rep.status = ST_WRITE;
            drop_session();
          end
        end else begin
          rep.status = ST_WRITE;
          drop_session();
        end
      end
      default: begin
        if (session_phase == PH_EXIT) begin
          if (image_valid) begin
            stay_com  = 1'b0;
            rep.start = 1'b1;
          end else begin
            rep.status = ST_VALID;
          end
        end else begin
          rep.status = ST_INVALID;
          drop_session();
        end
      end
    endcase
    rep.phase    = session_phase;
    rep.stay_com = stay_com;
    return rep;
  endfunction

  function automatic void report_reply(string why, reply_t want, reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected kind=%0d status=%0d phase=%0d erase=%0b write=%0b",
               $realtime, why, want.kind, want.status, want.phase, want.erase_req,
               want.write_req);
      $display("  expected addr=%h start=%0b com=%0b",
               want.waddr, want.start, want.stay_com);
      $display("  got kind=%0d status=%0d phase=%0d erase=%0b write=%0b",
               got.kind, got.status, got.phase, got.erase_req, got.write_req);
      $display("  got addr=%h start=%0b com=%0b",
               got.waddr, got.start, got.stay_com);
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      size_limit    = '0;
      fw_limit      = '0;
      hw_limit      = '0;
      checks_on     = CHECK_ENABLES_RST;
      app_base      = '0;
      stay_com      = 1'b0;
      drop_session();
      replies_q.delete();
      requests_seen = 0;
      replies_due   = 0;
      mismatches    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_SIZE_LIMIT: size_limit = cfg_data;
          REG_FW_VERSION_LIMIT: fw_limit   = cfg_data;
          REG_HW_VERSION_LIMIT: hw_limit   = cfg_data;
          REG_CHECK_ENABLES:    checks_on  = cfg_data[2:0];
          REG_APP_BASE_ADDRESS: app_base   = cfg_data;
          default: ;
        endcase
      end
      // replies leave before this edge's request is added
      if (out_valid && out_ready) begin
        got.kind      = cmd_t'(out_reply_kind);
        got.status    = status_t'(out_reply_status);
        got.phase     = phase_t'(out_phase_after);
        got.erase_req = out_erase_request;
        got.write_req = out_write_request;
        got.waddr     = out_write_address;
        got.start     = out_start_application;
        got.stay_com  = out_boot_reason_com;
        if (replies_q.size() == 0) begin
          report_reply("reply with no request waiting", '0, got);
        end else begin
          want = replies_q.pop_front();
          if (got !== want)
            report_reply("reply mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        replies_q.push_back(advance_session(cmd_t'(in_command), in_image_size,
                                            in_fw_version, in_hw_version,
                                            in_chunk_bytes, in_erase_ok,
                                            in_write_ok, in_image_valid));
        requests_seen++;
      end
      replies_due = replies_q.size();
    end
  end

endmodule

FILE: tb/bootloader_command_sequencer_tb.sv
// bootloader_command_sequencer_tb: drives firmware-update sessions, noise
// and register settings into the sequencer and gives the verdict
// depends on bcs_pkg, bootloader_command_sequencer and bcs_reply_checker
module bootloader_command_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcs_pkg::*;

  typedef struct {
    cmd_t        command;
    logic [31:0] image_size;
    logic [31:0] fw_version;
    logic [31:0] hw_version;
    logic [15:0] chunk_bytes;
    logic        erase_ok;
    logic        write_ok;
    logic        image_valid;
  } cmd_req_t;

  localparam logic [31:0] FW_CAP = 32'h0102_0304;
  localparam logic [31:0] HW_CAP = 32'd5;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_command = '0;
  logic [31:0]          in_image_size = '0;
  logic [31:0]          in_fw_version = '0;
  logic [31:0]          in_hw_version = '0;
  logic [15:0]          in_chunk_bytes = '0;
  logic                 in_erase_ok = 1'b0;
  logic                 in_write_ok = 1'b0;
  logic                 in_image_valid = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_reply_kind;
  logic [2:0]           out_reply_status;
  logic [1:0]           out_phase_after;
  logic                 out_erase_request;
  logic                 out_write_request;
  logic [31:0]          out_write_address;
  logic                 out_start_application;
  logic                 out_boot_reason_com;

  phase_t      session_phase;
  int unsigned requests_seen;
  int unsigned replies_due;
  int unsigned mismatches;

  int unsigned requests_sent = 0;
  int unsigned phase_start;
  bit          steady_tail = 1'b0;
  logic [31:0] fw_lim = '0;
  logic [31:0] hw_lim = '0;
  logic [31:0] size_pick;

  bootloader_command_sequencer uut (.*);

  bcs_reply_checker checker_i (.*);

  always #10 clk = ~clk;

  function automatic cmd_req_t random_request();
    cmd_req_t r;
    r.command     = cmd_t'($urandom_range(0, 3));
    r.image_size  = $urandom();
    r.fw_version  = $urandom();
    r.hw_version  = $urandom();
    r.chunk_bytes = 16'($urandom_range(0, 65535));
    r.erase_ok    = 1'($urandom_range(0, 1));
    r.write_ok    = 1'($urandom_range(0, 1));
    r.image_valid = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic cmd_req_t make_request(cmd_t cmd, logic [31:0] size = '0,
                                            logic [31:0] fw = '0, logic [31:0] hw = '0,
                                            logic [15:0] chunk = '0, logic erase_ok = 1'b1,
                                            logic write_ok = 1'b1,
                                            logic image_valid = 1'b1);
    cmd_req_t r;
    r.command     = cmd;
    r.image_size  = size;
    r.fw_version  = fw;
    r.hw_version  = hw;
    r.chunk_bytes = chunk;
    r.erase_ok    = erase_ok;
    r.write_ok    = write_ok;
    r.image_valid = image_valid;
    return r;
  endfunction

  function automatic logic [31:0] pick_at_most(logic [31:0] lim);
    if (lim == '1)
      return $urandom();
    return $urandom_range(lim, 0);
  endfunction

  // called at a rising edge; returns at the edge that took the request,
  // once the checker has seen it
  task automatic send_command(input cmd_req_t r);
    int gap;
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= r.command;
    in_image_size  <= r.image_size;
    in_fw_version  <= r.fw_version;
    in_hw_version  <= r.hw_version;
    in_chunk_bytes <= r.chunk_bytes;
    in_erase_ok    <= r.erase_ok;
    in_write_ok    <= r.write_ok;
    in_image_valid <= r.image_valid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    wait (requests_seen == requests_sent);
  endtask

  task automatic hold_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] size_lim, input logic [31:0] fw,
                                input logic [31:0] hw, input logic [2:0] checks,
                                input logic [31:0] base);
    hold_requests();
    write_reg(REG_IMAGE_SIZE_LIMIT, size_lim);
    write_reg(REG_FW_VERSION_LIMIT, fw);
    write_reg(REG_HW_VERSION_LIMIT, hw);
    write_reg(REG_CHECK_ENABLES, {29'd0, checks});
    write_reg(REG_APP_BASE_ADDRESS, base);
    cfg_valid <= 1'b0;
    fw_lim = fw;
    hw_lim = hw;
  endtask

  // one update session: open, prepare, chunks, exit; stops where the session dies
  task automatic run_session();
    cmd_req_t    r;
    logic [15:0] chunks [5];
    logic [31:0] total;
    int          n_chunks;
    int          exits;
    total    = '0;
    n_chunks = $urandom_range(1, 5);
    while (session_phase != PH_PREPARE) begin
      r = random_request();
      r.command = CMD_CONNECT;
      send_command(r);
    end
    for (int k = 0; k < n_chunks; k++) begin
      case ($urandom_range(0, 9))
        0:       chunks[k] = 16'h0000;
        1:       chunks[k] = 16'hFFFF;
        2:       chunks[k] = 16'($urandom_range(0, 65535));
        default: chunks[k] = 16'($urandom_range(1, 600));
      endcase
      total = total + {16'd0, chunks[k]};
    end
    r = random_request();
    r.command = CMD_PREPARE;
    if ($urandom_range(0, 9) != 0) begin
      // short announcement makes the chunks overshoot
      r.image_size = ($urandom_range(0, 9) == 0) ? total - $urandom_range(1, 50) : total;
      r.fw_version = pick_at_most(fw_lim);
      r.hw_version = pick_at_most(hw_lim);
    end
    r.erase_ok = ($urandom_range(0, 15) != 0);
    send_command(r);
    for (int k = 0; k < n_chunks && session_phase == PH_FLASH; k++) begin
      r = random_request();
      r.command     = CMD_FLASH;
      r.chunk_bytes = chunks[k];
      r.write_ok    = ($urandom_range(0, 19) != 0);
      send_command(r);
    end
    if (session_phase == PH_FLASH) begin
      r = random_request();
      r.command = CMD_FLASH;
      send_command(r);
    end
    exits = $urandom_range(1, 3);
    while (session_phase == PH_EXIT && exits > 0) begin
      r = random_request();
      r.command     = CMD_EXIT;
      r.image_valid = ($urandom_range(0, 3) != 0);
      send_command(r);
      exits--;
    end
  endtask

  // reply side: random stall bursts, none in the tail
  initial begin
    @(posedge clk);
    forever begin
      if (steady_tail) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: all limits zero, every check on
    send_command(make_request(CMD_EXIT));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE, 0, 0, 0, 0, 1'b0));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE));
    // zero-size image: first chunk is refused
    send_command(make_request(CMD_FLASH, 0, 0, 0, 16'd10));

    apply_settings(32'd100, FW_CAP, HW_CAP, 3'b111, 32'hFFFF_FF00);
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE, 32'd101, '1, '1));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE, 32'd100, FW_CAP + 1, HW_CAP + 1));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE, 32'd100, FW_CAP, HW_CAP + 1));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE, 32'd100, FW_CAP, HW_CAP));
    send_command(make_request(CMD_FLASH, 0, 0, 0, 16'd40, 1'b1, 1'b0));
    // overshoot with address wrap, then a chunk after the full image
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE, 32'd100, FW_CAP, HW_CAP));
    send_command(make_request(CMD_FLASH, 0, 0, 0, 16'hFFFF));
    send_command(make_request(CMD_FLASH, 0, 0, 0, 16'd1));
    send_command(make_request(CMD_CONNECT));
    send_command(make_request(CMD_PREPARE, 32'd100, FW_CAP, HW_CAP));
    send_command(make_request(CMD_FLASH, 0, 0, 0, 16'd100));
    send_command(make_request(CMD_EXIT, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    send_command(make_request(CMD_EXIT));
    send_command(make_request(CMD_FLASH));

    for (int p = 0; p < 8; p++) begin
      steady_tail = (p == 7);
      case (p)
        0: apply_settings('1, '1, '1, 3'b111, 32'h0);
        1: apply_settings('0, '0, '0, 3'b000, 32'hFFFF_FFFF);
        7: apply_settings('1, '1, '1, 3'b111, $urandom());
        default: begin
          case ($urandom_range(0, 2))
            0:       size_pick = '1;
            1:       size_pick = $urandom_range(0, 400000);
            default: size_pick = $urandom();
          endcase
          apply_settings(size_pick, ($urandom_range(0, 3) == 0) ? '1 : $urandom(),
                         $urandom(), 3'($urandom_range(0, 7)), $urandom());
        end
      endcase
      phase_start = requests_sent;
      while (requests_sent - phase_start < 200) begin
        if ($urandom_range(0, 7) == 0)
          send_command(random_request());
        else
          run_session();
      end
    end

    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && replies_due != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (replies_due != 0)
      $display("%0d replies never arrived", replies_due);
    if (mismatches == 0 && replies_due == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
